// ===== rtl/pste_pkg.sv =====
// Shared types and constants for the pulse template evaluator.
package pste_pkg;

	localparam int unsigned DATA_W = 16;
	localparam int unsigned CFG_IDX_W = 3;

	// Register indexes of the configuration port.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PULSE_START = 3'd0,
		REG_PULSE_AMPLITUDE = 3'd1,
		REG_DECAY_RATE = 3'd2,
		REG_RISE_RATE = 3'd3,
		REG_BASELINE_LEVEL = 3'd4
	} cfg_reg_t;

	// 1.0 in Q0.16 with one extra integer bit.
	localparam logic [DATA_W:0] ONE_Q16 = 17'h10000;

	// Load strobes for the two register stages of an exponential unit.
	typedef struct packed {
		logic load_idx;
		logic load_out;
	} exp_ctl_t;

endpackage

// ===== rtl/pste_exp_unit.sv =====
// Two-stage exp(-x) unit: table lookup, then linear interpolation.
module pste_exp_unit #(
	parameter int unsigned TABLE_BITS = 8
) (
	input  logic                          clk,
	input  pste_pkg::exp_ctl_t            ctl,
	input  logic [pste_pkg::DATA_W-1:0]   x,
	input  logic                          zero,
	output logic [pste_pkg::DATA_W-1:0]   y
);

	localparam int unsigned N = 1 << TABLE_BITS;
	localparam int unsigned F = pste_pkg::DATA_W - TABLE_BITS;
	localparam int unsigned TBL_W = (N + 1) * 16;

	function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] q;
		logic [64:0] rem;
		q = '0;
		rem = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[63:0], num[b]};
			if (rem >= {1'b0, den}) begin
				rem = rem - {1'b0, den};
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic logic [TBL_W-1:0] build_tbl();
		logic [63:0]      term;
		logic [63:0]      sum;
		logic [63:0]      k;
		logic [127:0]     r;
		logic [127:0]     p;
		logic [127:0]     e;
		logic [TBL_W-1:0] tv;
		term = 64'd1 << 62;
		sum = term;
		k = 64'd1;
		tv = '0;
		while (term != 64'd0) begin
			term = div_u64(term >> 8, k);
			if (k[0]) begin
				sum = sum - term;
			end else begin
				sum = sum + term;
			end
			k = k + 64'd1;
		end
		r = ({64'd0, sum} + (128'd1 << 29)) >> 30;
		for (int s = 0; s < 12 - int'(TABLE_BITS); s++) begin
			r = (r * r + (128'd1 << 31)) >> 32;
		end
		p = 128'd1 << 32;
		for (int i = 0; i <= int'(N); i++) begin
			e = (p + (128'd1 << 15)) >> 16;
			tv[16*i +: 16] = (e > 128'd65535) ? 16'hFFFF : e[15:0];
			p = (p * r + (128'd1 << 31)) >> 32;
		end
		return tv;
	endfunction

	localparam logic [TBL_W-1:0] TBL = build_tbl();

	logic [TABLE_BITS:0]         i_lo;
	logic [TABLE_BITS:0]         i_hi;
	logic [15:0]                 ta;
	logic [15:0]                 tb;
	logic [15:0]                 a_s1;
	logic [15:0]                 drop_s1;
	logic [F-1:0]                f_s1;
	logic [16+F-1:0]             prod;
	logic [15:0]                 y_s2;

	assign i_lo = {1'b0, x[15:F]};
	assign i_hi = i_lo + {{TABLE_BITS{1'b0}}, 1'b1};
	assign ta = TBL[16*i_lo +: 16];
	assign tb = TBL[16*i_hi +: 16];
	assign prod = {{F{1'b0}}, drop_s1} * {16'd0, f_s1};

	always_ff @(posedge clk) begin
		if (ctl.load_idx) begin
			a_s1 <= zero ? 16'd0 : ta;
			drop_s1 <= (zero || ta < tb) ? 16'd0 : ta - tb;
			f_s1 <= x[F-1:0];
		end
		if (ctl.load_out) begin
			y_s2 <= a_s1 - prod[16+F-1:F];
		end
	end

	assign y = y_s2;

endmodule

// ===== rtl/pulse_shape_template_eval_core.sv =====
// Top level of the pulse template evaluator.
// The block evaluates amplitude*exp(-decay*d)*(1-exp(-(rise*d)^4))+baseline at each
// sample time it receives, where d is the sample time minus the pulse start, and
// returns the baseline before the start. It takes one transaction per clock while the
// output is not stalled and passes each result through an eight-stage pipeline, in
// which the two squarings of the rise argument and the final products each have a
// stage of their own and each exponential unit spends one stage on its table lookup
// and one on the interpolation. Back pressure holds only the full stages, so bubbles
// are squeezed out while the output waits. The user must write registers only while
// no transaction is in flight; the block itself does not enforce this.
module pulse_shape_template_eval_core #(
	parameter int unsigned EXP_TABLE_BITS = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [pste_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pste_pkg::DATA_W-1:0]     cfg_data,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [pste_pkg::DATA_W-1:0]     s_tdata,   // [15:0] sample_time
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [pste_pkg::DATA_W-1:0]     m_tdata    // [15:0] template_value
);

	localparam int NS = 8;

	logic [15:0] start_q;
	logic [15:0] amp_q;
	logic [15:0] decay_q;
	logic [15:0] rise_q;
	logic [15:0] base_q;

	logic [NS:1]   vld_q;
	logic [NS+1:1] en;

	logic [15:0] d_s1;
	logic [31:0] dprod_s2;
	logic [31:0] g_s2;
	logic        dzero_s3;
	logic [15:0] darg_s3;
	logic        gbig_s3;
	logic [17:0] g2_s3;
	logic        gbig_s4;
	logic [15:0] g4_s4;
	logic [31:0] ad_s6;
	logic [16:0] v_s7;
	logic [15:0] out_s8;

	logic [33:0] gsq;
	logic [35:0] g2sq;
	logic [15:0] dec;
	logic [15:0] rexp;
	logic [16:0] rf;
	logic [48:0] prod;
	logic [17:0] sum;

	pste_pkg::exp_ctl_t dec_ctl;
	pste_pkg::exp_ctl_t rise_ctl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			amp_q <= '0;
			decay_q <= '0;
			rise_q <= '0;
			base_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				pste_pkg::REG_PULSE_START: start_q <= cfg_data;
				pste_pkg::REG_PULSE_AMPLITUDE: amp_q <= cfg_data;
				pste_pkg::REG_DECAY_RATE: decay_q <= cfg_data;
				pste_pkg::REG_RISE_RATE: rise_q <= cfg_data;
				pste_pkg::REG_BASELINE_LEVEL: base_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// A stage moves when it is empty or the stage after it moves.
	always_comb begin
		en[NS+1] = m_tready;
		for (int k = NS; k >= 1; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = NS; k >= 2; k--) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
			if (en[1]) begin
				vld_q[1] <= s_tvalid;
			end
		end
	end

	assign s_tready = en[1];

	assign gsq = {17'd0, g_s2[16:0]} * {17'd0, g_s2[16:0]};
	assign g2sq = {18'd0, g2_s3} * {18'd0, g2_s3};
	assign rf = pste_pkg::ONE_Q16 - {1'b0, rexp};
	assign prod = {17'd0, ad_s6} * {32'd0, rf};
	assign sum = {1'b0, v_s7} + {2'b00, base_q};

	// Before the start the offset is forced to zero, which makes the product zero.
	always_ff @(posedge clk) begin
		if (en[1]) begin
			d_s1 <= (s_tdata < start_q) ? 16'd0 : s_tdata - start_q;
		end
		if (en[2]) begin
			dprod_s2 <= {16'd0, decay_q} * {16'd0, d_s1};
			g_s2 <= {16'd0, rise_q} * {16'd0, d_s1};
		end
		if (en[3]) begin
			dzero_s3 <= |dprod_s2[31:20];
			darg_s3 <= dprod_s2[19:4];
			gbig_s3 <= |g_s2[31:17];
			g2_s3 <= gsq[33:16];
		end
		if (en[4]) begin
			gbig_s4 <= gbig_s3;
			g4_s4 <= g2sq[35:20];
		end
		if (en[6]) begin
			ad_s6 <= {16'd0, amp_q} * {16'd0, dec};
		end
		if (en[7]) begin
			v_s7 <= prod[48:32];
		end
		if (en[8]) begin
			out_s8 <= (|sum[17:16]) ? 16'hFFFF : sum[15:0];
		end
	end

	assign dec_ctl.load_idx = en[4];
	assign dec_ctl.load_out = en[5];
	assign rise_ctl.load_idx = en[5];
	assign rise_ctl.load_out = en[6];

	pste_exp_unit #(
		.TABLE_BITS(EXP_TABLE_BITS)
	) u_dec_exp (
		.clk(clk),
		.ctl(dec_ctl),
		.x(darg_s3),
		.zero(dzero_s3),
		.y(dec)
	);

	pste_exp_unit #(
		.TABLE_BITS(EXP_TABLE_BITS)
	) u_rise_exp (
		.clk(clk),
		.ctl(rise_ctl),
		.x(g4_s4),
		.zero(gbig_s4),
		.y(rexp)
	);

	assign m_tvalid = vld_q[NS];
	assign m_tdata = out_s8;

endmodule

// ===== rtl/pste_checker.sv =====
// Port-level checker for the pulse template evaluator, bound to the top level.
module pste_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_tvalid,
	input logic                         s_tready,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [pste_pkg::DATA_W-1:0]  m_tdata
);

	logic [3:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + {3'd0, s_tvalid && s_tready} - {3'd0, m_tvalid && m_tready};
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("Stalled output changed.");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 4'd0 |-> !m_tvalid)
		else $error("Output valid with no transaction in flight.");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 4'd8)
		else $error("More transactions in flight than pipeline stages.");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("Input stalled without output back pressure.");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 4'd8 && m_tvalid && !m_tready |-> !s_tready)
		else $error("Input accepted while the pipeline is full and stalled.");

endmodule

bind pulse_shape_template_eval_core pste_checker u_pste_checker (.*);
